[sv/rtp_stream_monitor_unit_assert.svh]
// Assertion macros used by the monitor's control RTL file, rsm_ctrl.sv.
// They expect clk and rst_n in the enclosing scope.
`ifndef RTP_STREAM_MONITOR_UNIT_ASSERT_SVH
`define RTP_STREAM_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RSM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsm assertion failed");

// Next-cycle implication.
`define RSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsm assertion failed");

`endif

[sv/rsm_pkg.sv]
`default_nettype none
package rsm_pkg;

  localparam int SEQ_W     = 16;
  localparam int SRC_W     = 32;
  localparam int LEN_W     = 16;
  localparam int PKT_W     = 16;
  localparam int LOSS_W    = 48;
  localparam int BYTE_W    = 32;
  localparam int BITS_W    = 35;
  localparam int TICK_W    = 32;
  localparam int TS_W      = 9;
  localparam int DVS_W     = TICK_W + 1;
  localparam int DIV_STEPS = BITS_W;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } ctrl_state_t;

  typedef struct packed {
    logic pkt_ld;
    logic tick_ld;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

[sv/rsm_if.sv]
`default_nettype none
interface rsm_in_if;
  import rsm_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SEQ_W-1:0]  seq_num;
  logic [SRC_W-1:0]  source_id;
  logic [LEN_W-1:0]  datagram_bytes;

  modport source (output valid, cmd, seq_num, source_id, datagram_bytes, input ready);
  modport sink   (input valid, cmd, seq_num, source_id, datagram_bytes, output ready);
endinterface

interface rsm_out_if;
  import rsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [PKT_W-1:0]  packet_total;
  logic [LOSS_W-1:0] lost_packets;
  logic              source_mismatch;
  logic [TS_W-1:0]   ts_packets;
  logic [BITS_W-1:0] interval_bits;
  logic [BITS_W-1:0] peak_bits;
  logic [BITS_W-1:0] mean_bits;

  modport source (output valid, packet_total, lost_packets, source_mismatch, ts_packets,
                  interval_bits, peak_bits, mean_bits, input ready);
  modport sink   (input valid, packet_total, lost_packets, source_mismatch, ts_packets,
                  interval_bits, peak_bits, mean_bits, output ready);
endinterface
`default_nettype wire

[sv/rtp_stream_monitor_unit.sv]
`default_nettype none
// RTP stream monitor. Each input beat is a received packet (cmd = 0) or a one-second tick
// (cmd = 1) and yields exactly one result beat. Packets can be accepted back to back as long
// as the result register drains, and a new packet is taken in the same cycle the previous
// result is taken. A tick occupies the block from accept through 35 steps of the bit-serial
// divider that updates the running mean to commit; the input stays not ready until the tick
// result is loaded. No clearing pass follows reset.
module rtp_stream_monitor_unit #(
  parameter int unsigned TS_PACKET_BYTES  = 188,
  parameter int unsigned RTP_HEADER_BYTES = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rsm_in_if.sink    in_ch,
  rsm_out_if.source out_ch
);
  import rsm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rsm_dp #(
    .TS_PACKET_BYTES  (TS_PACKET_BYTES),
    .RTP_HEADER_BYTES (RTP_HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .seq_num         (in_ch.seq_num),
    .source_id       (in_ch.source_id),
    .datagram_bytes  (in_ch.datagram_bytes),
    .packet_total    (out_ch.packet_total),
    .lost_packets    (out_ch.lost_packets),
    .source_mismatch (out_ch.source_mismatch),
    .ts_packets      (out_ch.ts_packets),
    .interval_bits   (out_ch.interval_bits),
    .peak_bits       (out_ch.peak_bits),
    .mean_bits       (out_ch.mean_bits)
  );
endmodule
`default_nettype wire

[sv/rsm_div.sv]
`default_nettype none
module rsm_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rsm_pkg::BITS_W-1:0] dividend,
  input  wire logic [rsm_pkg::DVS_W-1:0]  divisor,
  output      logic                       busy,
  output      logic                       done,
  output      logic [rsm_pkg::BITS_W-1:0] quotient,
  output      logic                       rem_nz
);
  import rsm_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BITS_W-1:0]  dvd_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVS_W-1:0]   rem_r;
  logic [DVS_W+1:0]   trial;

  assign trial = {1'b0, rem_r, dvd_r[BITS_W-1]} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (trial[DVS_W+1]) begin
        rem_r <= {rem_r[DVS_W-2:0], dvd_r[BITS_W-1]};
        dvd_r <= {dvd_r[BITS_W-2:0], 1'b0};
      end else begin
        rem_r <= trial[DVS_W-1:0];
        dvd_r <= {dvd_r[BITS_W-2:0], 1'b1};
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;
  assign rem_nz   = |rem_r;
endmodule
`default_nettype wire

[sv/rsm_dp.sv]
`default_nettype none
module rsm_dp #(
  parameter int unsigned TS_PACKET_BYTES  = 188,
  parameter int unsigned RTP_HEADER_BYTES = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rsm_pkg::ctrl_cmd_t         cmd,
  output      rsm_pkg::dp_stat_t          stat,
  input  wire logic [rsm_pkg::SEQ_W-1:0]  seq_num,
  input  wire logic [rsm_pkg::SRC_W-1:0]  source_id,
  input  wire logic [rsm_pkg::LEN_W-1:0]  datagram_bytes,
  output      logic [rsm_pkg::PKT_W-1:0]  packet_total,
  output      logic [rsm_pkg::LOSS_W-1:0] lost_packets,
  output      logic                       source_mismatch,
  output      logic [rsm_pkg::TS_W-1:0]   ts_packets,
  output      logic [rsm_pkg::BITS_W-1:0] interval_bits,
  output      logic [rsm_pkg::BITS_W-1:0] peak_bits,
  output      logic [rsm_pkg::BITS_W-1:0] mean_bits
);
  import rsm_pkg::*;

  localparam int PAY_W = LEN_W + 1;
  localparam int K     = PAY_W + $clog2(TS_PACKET_BYTES);
  localparam int MW    = K + 1;
  localparam int PW    = PAY_W + MW;
  localparam int QW    = PW - K;
  localparam longint unsigned RECIP_L =
    ((64'd1 << K) + 64'(TS_PACKET_BYTES) - 64'd1) / 64'(TS_PACKET_BYTES);
  localparam logic [63:0] RECIP_V = RECIP_L;
  localparam logic [MW-1:0] RECIP = RECIP_V[MW-1:0];

  logic [SRC_W-1:0]  latched_source_r;
  logic [SEQ_W-1:0]  expected_seq_r;
  logic [PKT_W-1:0]  packet_counter_r;
  logic [LOSS_W-1:0] loss_total_r;
  logic [BYTE_W-1:0] byte_accum_r;
  logic [BITS_W-1:0] last_interval_r;
  logic [BITS_W-1:0] peak_interval_r;
  logic [BITS_W-1:0] mean_interval_r;
  logic [TICK_W-1:0] tick_total_r;
  logic              neg_r;

  logic [PKT_W-1:0]  o_packet_total_r;
  logic [LOSS_W-1:0] o_lost_packets_r;
  logic              o_source_mismatch_r;
  logic [TS_W-1:0]   o_ts_packets_r;
  logic [BITS_W-1:0] o_interval_bits_r;
  logic [BITS_W-1:0] o_peak_bits_r;
  logic [BITS_W-1:0] o_mean_bits_r;

  logic              mismatch;
  logic [PKT_W-1:0]  pkt_cnt_nxt;
  logic [SEQ_W-1:0]  gap;
  logic [LOSS_W:0]   loss_sum;
  logic [LOSS_W-1:0] loss_nxt;
  logic [BYTE_W:0]   byte_sum;
  logic [BYTE_W-1:0] byte_nxt;
  logic              pay_ok;
  logic [LEN_W-1:0]  pay;
  logic [PAY_W-1:0]  pay_rnd;
  logic [PW-1:0]     ts_prod;
  logic [QW-1:0]     ts_q;
  logic [TS_W-1:0]   ts_val;
  logic [BITS_W-1:0] x_bits;
  logic              x_neg;
  logic [BITS_W-1:0] diff;
  logic [DVS_W-1:0]  divisor;
  logic [BITS_W-1:0] div_q;
  logic              div_rnz;
  logic              div_busy;
  logic              div_done;
  logic [BITS_W-1:0] mean_nxt;
  logic [TICK_W-1:0] tick_nxt;

  assign mismatch    = (latched_source_r != '0) && (latched_source_r != source_id);
  assign pkt_cnt_nxt = packet_counter_r + PKT_W'(1);
  assign gap         = seq_num - expected_seq_r;
  assign loss_sum    = {1'b0, loss_total_r} + {{(LOSS_W + 1 - SEQ_W){1'b0}}, gap};
  assign loss_nxt    = loss_sum[LOSS_W] ? {LOSS_W{1'b1}} : loss_sum[LOSS_W-1:0];
  assign byte_sum    = {1'b0, byte_accum_r} + {{(BYTE_W + 1 - LEN_W){1'b0}}, datagram_bytes};
  assign byte_nxt    = byte_sum[BYTE_W] ? {BYTE_W{1'b1}} : byte_sum[BYTE_W-1:0];

  assign pay_ok  = datagram_bytes > LEN_W'(RTP_HEADER_BYTES);
  assign pay     = datagram_bytes - LEN_W'(RTP_HEADER_BYTES);
  assign pay_rnd = {1'b0, pay} + PAY_W'(TS_PACKET_BYTES - 1);
  assign ts_prod = {{MW{1'b0}}, pay_rnd} * {{PAY_W{1'b0}}, RECIP};
  assign ts_q    = ts_prod[PW-1:K];
  always_comb begin
    if (!pay_ok) begin
      ts_val = '0;
    end else if (|ts_q[QW-1:TS_W]) begin
      ts_val = {TS_W{1'b1}};
    end else begin
      ts_val = ts_q[TS_W-1:0];
    end
  end

  assign x_bits  = {byte_accum_r, 3'b000};
  assign x_neg   = x_bits < mean_interval_r;
  assign diff    = x_neg ? (mean_interval_r - x_bits) : (x_bits - mean_interval_r);
  assign divisor = {1'b0, tick_total_r} + DVS_W'(1);

  assign mean_nxt = neg_r ? (mean_interval_r - div_q - BITS_W'(div_rnz))
                          : (mean_interval_r + div_q);
  assign tick_nxt = (&tick_total_r) ? tick_total_r : tick_total_r + TICK_W'(1);

  rsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.tick_ld),
    .dividend (diff),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rnz)
  );

  assign stat.div_busy = div_busy;
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_source_r <= '0;
      expected_seq_r   <= '0;
      packet_counter_r <= '0;
      loss_total_r     <= '0;
      byte_accum_r     <= '0;
      last_interval_r  <= '0;
      peak_interval_r  <= '0;
      mean_interval_r  <= '0;
      tick_total_r     <= '0;
      neg_r            <= 1'b0;
    end else begin
      if (cmd.pkt_ld) begin
        if (latched_source_r == '0) begin
          latched_source_r <= source_id;
        end
        packet_counter_r <= pkt_cnt_nxt;
        loss_total_r     <= loss_nxt;
        expected_seq_r   <= seq_num + SEQ_W'(1);
        byte_accum_r     <= byte_nxt;
      end
      if (cmd.tick_ld) begin
        last_interval_r <= x_bits;
        if (x_bits > peak_interval_r) begin
          peak_interval_r <= x_bits;
        end
        neg_r        <= x_neg;
        byte_accum_r <= '0;
      end
      if (cmd.commit) begin
        mean_interval_r <= mean_nxt;
        tick_total_r    <= tick_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pkt_ld) begin
      o_packet_total_r    <= pkt_cnt_nxt;
      o_lost_packets_r    <= loss_nxt;
      o_source_mismatch_r <= mismatch;
      o_ts_packets_r      <= ts_val;
      o_interval_bits_r   <= last_interval_r;
      o_peak_bits_r       <= peak_interval_r;
      o_mean_bits_r       <= mean_interval_r;
    end else if (cmd.commit) begin
      o_packet_total_r    <= packet_counter_r;
      o_lost_packets_r    <= loss_total_r;
      o_source_mismatch_r <= 1'b0;
      o_ts_packets_r      <= '0;
      o_interval_bits_r   <= last_interval_r;
      o_peak_bits_r       <= peak_interval_r;
      o_mean_bits_r       <= mean_nxt;
    end
  end

  assign packet_total    = o_packet_total_r;
  assign lost_packets    = o_lost_packets_r;
  assign source_mismatch = o_source_mismatch_r;
  assign ts_packets      = o_ts_packets_r;
  assign interval_bits   = o_interval_bits_r;
  assign peak_bits       = o_peak_bits_r;
  assign mean_bits       = o_mean_bits_r;
endmodule
`default_nettype wire

[sv/rsm_ctrl.sv]
`default_nettype none
`include "rtp_stream_monitor_unit_assert.svh"
module rsm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_cmd,
  output      logic               in_ready,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      rsm_pkg::ctrl_cmd_t cmd,
  input  wire rsm_pkg::dp_stat_t  stat
);
  import rsm_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;
  logic        accept;

  assign slot_free   = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE) && slot_free;
  assign accept      = in_valid && in_ready;
  assign cmd.pkt_ld  = accept && (in_cmd == CMD_PACKET);
  assign cmd.tick_ld = accept && (in_cmd == CMD_TICK);
  assign cmd.commit  = (state_r == S_DIV) && stat.div_done;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.tick_ld) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.pkt_ld || cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RSM_ASSERT_IMPL(a_idle_div_quiet, state_r == S_IDLE, !stat.div_busy && !stat.div_done)
  `RSM_ASSERT_NEXT(a_tick_starts_div, cmd.tick_ld, (state_r == S_DIV) && stat.div_busy)
  `RSM_ASSERT_NEXT(a_commit_shows_beat, cmd.commit, out_valid_r && (state_r == S_IDLE))
  `RSM_ASSERT_IMPL(a_commit_slot_free, cmd.commit, !out_valid_r || out_ready)
endmodule
`default_nettype wire

[tb/rtp_stream_monitor_unit_tb.sv]
`timescale 1ns / 100ps
module rtp_stream_monitor_unit_tb;
  import rsm_pkg::*;

  localparam int unsigned TS_BYTES  = 188;
  localparam int unsigned HDR_BYTES = 12;
  localparam logic [63:0] LOSS_MAX  = (64'd1 << LOSS_W) - 64'd1;
  localparam logic [63:0] BYTE_MAX  = (64'd1 << BYTE_W) - 64'd1;
  localparam logic [63:0] TICK_MAX  = (64'd1 << TICK_W) - 64'd1;

  typedef struct packed {
    logic             cmd;
    logic [SEQ_W-1:0] seq;
    logic [SRC_W-1:0] src;
    logic [LEN_W-1:0] len;
  } monitor_req_t;

  typedef struct packed {
    logic [PKT_W-1:0]  pkt;
    logic [LOSS_W-1:0] lost;
    logic              mism;
    logic [TS_W-1:0]   ts;
    logic [BITS_W-1:0] interval;
    logic [BITS_W-1:0] peak;
    logic [BITS_W-1:0] mean;
  } stream_status_t;

  logic clk = 1'b0;
  logic rst_n;

  rsm_in_if  in_bus ();
  rsm_out_if out_bus ();

  rtp_stream_monitor_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic [SRC_W-1:0]  stream_src  = '0;
  logic [SEQ_W-1:0]  next_seq    = '0;
  logic [PKT_W-1:0]  pkt_count   = '0;
  logic [LOSS_W-1:0] loss_sum    = '0;
  logic [BYTE_W-1:0] byte_sum    = '0;
  logic [BITS_W-1:0] last_bits   = '0;
  logic [BITS_W-1:0] top_bits    = '0;
  logic [BITS_W-1:0] avg_bits    = '0;
  logic [TICK_W-1:0] tick_count  = '0;

  stream_status_t status_q[$];
  int unsigned    mismatch_count = 0;
  bit             steady = 1'b0;
  int unsigned    rx_hold = 0;

  function automatic void predict_status(monitor_req_t r);
    stream_status_t s;
    logic [SEQ_W-1:0] gap;
    logic [63:0] wide;
    logic [63:0] x;
    logic [63:0] divisor;
    s = '0;
    if (r.cmd == CMD_PACKET) begin
      if (stream_src == '0) begin
        stream_src = r.src;
      end else if (stream_src != r.src) begin
        s.mism = 1'b1;
      end
      pkt_count = pkt_count + 1'b1;
      if (r.seq != next_seq) begin
        gap = r.seq - next_seq;
        wide = {16'd0, loss_sum} + gap;
        loss_sum = (wide > LOSS_MAX) ? LOSS_MAX[LOSS_W-1:0] : wide[LOSS_W-1:0];
      end
      next_seq = r.seq + 1'b1;
      wide = {32'd0, byte_sum} + r.len;
      byte_sum = (wide > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : wide[BYTE_W-1:0];
      if (r.len > HDR_BYTES) begin
        wide = (64'(r.len) - HDR_BYTES + TS_BYTES - 1) / TS_BYTES;
        s.ts = (wide > 64'd511) ? 9'd511 : wide[TS_W-1:0];
      end
    end else begin
      x = {29'd0, byte_sum, 3'b000};
      last_bits = x[BITS_W-1:0];
      if (last_bits > top_bits) top_bits = last_bits;
      divisor = {32'd0, tick_count} + 64'd1;
      if (x >= avg_bits) begin
        wide = avg_bits + (x - avg_bits) / divisor;
      end else begin
        wide = avg_bits - ((avg_bits - x) + divisor - 64'd1) / divisor;
      end
      avg_bits = wide[BITS_W-1:0];
      if (tick_count != TICK_MAX[TICK_W-1:0]) tick_count = tick_count + 1'b1;
      byte_sum = '0;
    end
    s.pkt      = pkt_count;
    s.lost     = loss_sum;
    s.interval = last_bits;
    s.peak     = top_bits;
    s.mean     = avg_bits;
    status_q.push_back(s);
  endfunction

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
    end
  endtask

  task automatic check_status();
    stream_status_t want;
    if (status_q.size() == 0) begin
      flag_mismatch("unexpected result beat", out_bus.packet_total, 0);
      return;
    end
    want = status_q.pop_front();
    if (out_bus.packet_total !== want.pkt)
      flag_mismatch("packet_total", out_bus.packet_total, want.pkt);
    if (out_bus.lost_packets !== want.lost)
      flag_mismatch("lost_packets", out_bus.lost_packets, want.lost);
    if (out_bus.source_mismatch !== want.mism)
      flag_mismatch("source_mismatch", out_bus.source_mismatch, want.mism);
    if (out_bus.ts_packets !== want.ts)
      flag_mismatch("ts_packets", out_bus.ts_packets, want.ts);
    if (out_bus.interval_bits !== want.interval)
      flag_mismatch("interval_bits", out_bus.interval_bits, want.interval);
    if (out_bus.peak_bits !== want.peak)
      flag_mismatch("peak_bits", out_bus.peak_bits, want.peak);
    if (out_bus.mean_bits !== want.mean)
      flag_mismatch("mean_bits", out_bus.mean_bits, want.mean);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) check_status();
  end

  // result side: random stalls, or a counted hold-off
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  task automatic send_item(monitor_req_t r);
    if (!steady) begin
      while ($urandom_range(99) < 25) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid          <= 1'b1;
    in_bus.cmd            <= r.cmd;
    in_bus.seq_num        <= r.seq;
    in_bus.source_id      <= r.src;
    in_bus.datagram_bytes <= r.len;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_status(r);
  endtask

  task automatic send_packet(logic [SEQ_W-1:0] seq, logic [SRC_W-1:0] src,
                             logic [LEN_W-1:0] len);
    monitor_req_t r;
    r = '{cmd: CMD_PACKET, seq: seq, src: src, len: len};
    send_item(r);
  endtask

  task automatic send_tick();
    monitor_req_t r;
    r = '{cmd: CMD_TICK, seq: SEQ_W'($urandom), src: $urandom, len: LEN_W'($urandom)};
    send_item(r);
  endtask

  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (status_q.size() != 0);
  endtask

  task automatic test_source_latch();
    send_packet(16'd0, 32'h0000_0000, 16'd0);
    send_packet(16'd1, 32'h0000_0000, 16'd12);
    send_packet(16'd2, 32'hFFFF_FFFF, 16'd13);
    send_packet(16'd3, 32'h1234_5678, 16'd200);
    send_packet(16'd4, 32'h0000_0000, 16'd201);
    send_packet(16'd5, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_sequence_gaps();
    send_packet(16'd10, stream_src, 16'd1328);
    send_packet(16'd10, stream_src, 16'd1328);
    send_packet(16'hFFFF, stream_src, 16'd1328);
    send_packet(16'd0, stream_src, 16'd1328);
    send_packet(16'hFFFF, stream_src, 16'd1328);
    send_packet(16'd0, stream_src, 16'd1328);
  endtask

  task automatic test_interval_stats();
    send_tick();
    send_tick();
    send_packet(next_seq, stream_src, 16'd1500);
    send_packet(next_seq, stream_src, 16'd1500);
    send_tick();
    send_packet(next_seq, stream_src, 16'd100);
    send_tick();
    send_tick();
  endtask

  task automatic test_output_backpressure();
    rx_hold = 300;
    repeat (30) send_packet(next_seq, stream_src, 16'd1328);
    send_tick();
  endtask

  task automatic test_sender_pause();
    repeat (10) send_packet(next_seq, stream_src, 16'd764);
    wait_for_drain();
    send_tick();
    send_packet(next_seq, stream_src, 16'd764);
  endtask

  // run full-length datagrams back to back
  task automatic test_large_datagrams();
    steady = 1'b1;
    repeat (64) send_packet(next_seq, stream_src, 16'hFFFF);
    send_tick();
    send_tick();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    monitor_req_t r;
    int unsigned pick;
    for (int i = 0; i < 1100; i++) begin
      steady = (i >= 400 && i < 700);
      pick = $urandom_range(99);
      r.cmd = CMD_PACKET;
      r.seq = next_seq;
      r.src = stream_src;
      r.len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(40))
                                       : LEN_W'(HDR_BYTES + TS_BYTES * $urandom_range(1, 7));
      if (pick < 7) begin
        send_tick();
        continue;
      end else if (pick < 75) begin
      end else if (pick < 85) begin
        r.seq = next_seq + SEQ_W'($urandom_range(1, 50));
      end else if (pick < 92) begin
        r.src = $urandom;
      end else begin
        r.seq = SEQ_W'($urandom);
        r.src = $urandom;
        r.len = LEN_W'($urandom);
      end
      send_item(r);
    end
    steady = 1'b0;
  endtask

  initial begin
    in_bus.valid          <= 1'b0;
    in_bus.cmd            <= CMD_PACKET;
    in_bus.seq_num        <= '0;
    in_bus.source_id      <= '0;
    in_bus.datagram_bytes <= '0;
    rst_n                 <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_source_latch();
    test_sequence_gaps();
    test_interval_stats();
    test_output_backpressure();
    test_sender_pause();
    test_large_datagrams();
    test_random_traffic();

    wait_for_drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
